/* rtl/assert_macros.svh */
// Assertion helpers, sampled on the rising edge of clock and off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define SRS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen
`define SRS_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* rtl/srs_pkg.sv */
package srs_pkg;

   localparam int BUF_DEPTH    = 16;
   localparam int IDX_W        = $clog2(BUF_DEPTH);
   localparam int OCC_W        = $clog2(BUF_DEPTH + 1);
   localparam int MAX_SEQ_BITS = 16;
   localparam int SEQ_W        = 16;
   localparam int TX_W         = 24;
   localparam int RTT_W        = 48;

   localparam logic [3:0]  ATTEMPT_LIMIT   = 4'd10;
   localparam logic [15:0] INIT_TIMEOUT_MS = 16'd300;
   localparam int          US_PER_MS       = 1000;
   localparam logic [15:0] DELIV_ADAPT_MIN = 16'd10;

   // request kinds
   localparam logic [1:0] KIND_GEN     = 2'd0;
   localparam logic [1:0] KIND_ACK     = 2'd1;
   localparam logic [1:0] KIND_SERVICE = 2'd2;

   // result events
   localparam logic [1:0] EV_TX    = 2'd0;
   localparam logic [1:0] EV_ABORT = 2'd1;
   localparam logic [1:0] EV_END   = 2'd2;

   // register indexes
   localparam logic [1:0] REG_SEQ_BITS     = 2'd0;
   localparam logic [1:0] REG_WINDOW_SIZE  = 2'd1;
   localparam logic [1:0] REG_BUFFER_LIMIT = 2'd2;
   localparam logic [1:0] REG_PACKET_TOTAL = 2'd3;

   typedef struct packed {
      logic [15:0] seq;
      logic [3:0]  attempts;
      logic        sent;
      logic        acked;
      logic [31:0] send_time;
      logic [31:0] first_time;
      logic [31:0] ack_stamp;
      logic [15:0] timeout_ms;
   } entry_type;

endpackage

/* rtl/selective_repeat_sender_unit.sv */
// Channel   Dir  Payload
// req_      in   tuser: kind; tdata: ack_seq[15:0], now_us[47:16]
// rsp_      out  tuser: event_res; tdata: seq, attempt, delivered, transmissions, done_res;
//                tlast: last
// csr_      in   index 0..3, data 16 bits
//
// Generate writes its entry directly; ack does a read-modify-write of the entry memory.
// Service dispatches, then checks and retires acked entries at the head, runs the timeout
// division once more than ten packets are delivered, reads, limits and decides each window
// entry in turn, and closes the pass.
// Reset is synchronous and clears control state; the entry memory is not cleared.
// A stalled result holds the sequencer; a new request is taken once the last result is loaded.
`include "assert_macros.svh"

module selective_repeat_sender_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [47:0] req_tdata,   // ack_seq[15:0], now_us[47:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // event_res
   output logic [63:0] rsp_tdata,   // seq, attempt, delivered, transmissions, done_res
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import srs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISP, S_ACK_WR, S_RET_RD, S_RET_CHK, S_DIV_INIT, S_DIV,
      S_WIN_RD, S_WIN_LIM, S_WIN_DEC, S_END
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]  seq_bits_ff, seq_bits_in, window_ff, window_in, limit_ff, limit_in;
   logic [15:0] total_ff, total_in;

   logic [1:0]  kind_ff, kind_in;
   logic [15:0] ack_ff, ack_in;
   logic [31:0] now_ff, now_in;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [15:0] base_ff, base_in, gen_ff, gen_in, deliv_ff, deliv_in;
   logic [TX_W-1:0]  tx_ff, tx_in;
   logic [RTT_W-1:0] rtt_ff, rtt_in;
   logic halted_ff, halted_in;

   logic [OCC_W-1:0] win_i_ff, win_i_in, win_n_ff, win_n_in;
   logic [15:0] tmo_ff, tmo_in;
   logic [48:0] div_num_ff, div_num_in, div_q_ff, div_q_in;
   logic [26:0] div_rem_ff, div_rem_in;
   logic [25:0] div_den_ff, div_den_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;
   logic [26:0] lim_ff, lim_in;
   logic [31:0] diff_ff, diff_in;

   logic        rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_ev_ff, rsp_ev_in;
   logic [15:0] rsp_seq_ff, rsp_seq_in, rsp_deliv_ff, rsp_deliv_in;
   logic [3:0]  rsp_att_ff, rsp_att_in;
   logic [TX_W-1:0] rsp_tx_ff, rsp_tx_in;
   logic        rsp_done_ff, rsp_done_in;

   // entry memory
   entry_type mem [BUF_DEPTH];
   entry_type mem_rd_ff, mem_wdata;
   logic mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;

   // combinational helpers
   logic [4:0]  eff_bits, win_cap, lim_cap;
   logic [15:0] seq_mask, ack_off;
   logic        out_free;
   logic [48:0] rtt_sum;
   logic [31:0] rtt_one;
   logic [26:0] div_r2, div_q_last;
   logic        div_ge;
   logic [48:0] div_qf;
   logic        skip;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'd0, rsp_done_ff, rsp_tx_ff, rsp_deliv_ff, rsp_att_ff, rsp_seq_ff};

   // effective register values
   always_comb begin
      if (seq_bits_ff == 5'd0) eff_bits = 5'd1;
      else if (seq_bits_ff > 5'(MAX_SEQ_BITS)) eff_bits = 5'(MAX_SEQ_BITS);
      else eff_bits = seq_bits_ff;
      seq_mask = 16'((17'd1 << eff_bits) - 17'd1);
      win_cap  = (window_ff > 5'(BUF_DEPTH)) ? 5'(BUF_DEPTH) : window_ff;
      lim_cap  = (limit_ff  > 5'(BUF_DEPTH)) ? 5'(BUF_DEPTH) : limit_ff;
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ack_off    = (ack_ff - base_ff) & seq_mask;
   assign rtt_one    = mem_rd_ff.ack_stamp - mem_rd_ff.first_time;
   assign rtt_sum    = {1'b0, rtt_ff} + 49'(rtt_one);
   assign div_r2     = {div_rem_ff[25:0], div_num_ff[48]};
   assign div_ge     = div_r2 >= {1'b0, div_den_ff};
   assign div_q_last = div_ge ? div_r2 - {1'b0, div_den_ff} : div_r2;
   assign div_qf     = {div_q_ff[47:0], div_ge};
   assign skip       = mem_rd_ff.acked || (mem_rd_ff.sent && (diff_ff < 32'(lim_ff)));

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      seq_bits_in = seq_bits_ff; window_in = window_ff; limit_in = limit_ff;
      total_in = total_ff;
      kind_in = kind_ff; ack_in = ack_ff; now_in = now_ff;
      head_in = head_ff; occ_in = occ_ff; base_in = base_ff; gen_in = gen_ff;
      deliv_in = deliv_ff; tx_in = tx_ff; rtt_in = rtt_ff; halted_in = halted_ff;
      win_i_in = win_i_ff; win_n_in = win_n_ff; tmo_in = tmo_ff;
      div_num_in = div_num_ff; div_q_in = div_q_ff; div_rem_in = div_rem_ff;
      div_den_in = div_den_ff; div_cnt_in = div_cnt_ff;
      lim_in = lim_ff; diff_in = diff_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in = rsp_last_ff; rsp_ev_in = rsp_ev_ff; rsp_seq_in = rsp_seq_ff;
      rsp_att_in = rsp_att_ff; rsp_deliv_in = rsp_deliv_ff; rsp_tx_in = rsp_tx_ff;
      rsp_done_in = rsp_done_ff;
      mem_we = 1'b0; mem_waddr = '0; mem_wdata = mem_rd_ff;
      mem_re = 1'b0; mem_raddr = '0;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            REG_SEQ_BITS:     seq_bits_in = csr_data[4:0];
            REG_WINDOW_SIZE:  window_in   = csr_data[4:0];
            REG_BUFFER_LIMIT: limit_in    = csr_data[4:0];
            REG_PACKET_TOTAL: total_in    = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               ack_in   = req_tdata[15:0];
               now_in   = req_tdata[47:16];
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_IDLE;
            if (!halted_ff) begin
               case (kind_ff)
                  KIND_GEN: begin
                     if (gen_ff < total_ff && occ_ff < lim_cap) begin
                        mem_we    = 1'b1;
                        mem_waddr = head_ff + occ_ff[IDX_W-1:0];
                        mem_wdata = '{seq: gen_ff & seq_mask, attempts: 4'd0, sent: 1'b0,
                                      acked: 1'b0, send_time: now_ff, first_time: now_ff,
                                      ack_stamp: now_ff, timeout_ms: INIT_TIMEOUT_MS};
                        if (occ_ff == '0) base_in = gen_ff & seq_mask;
                        occ_in = occ_ff + 1'b1;
                        gen_in = gen_ff + 16'd1;
                     end
                  end
                  KIND_ACK: begin
                     if (occ_ff != '0 && ack_ff <= seq_mask && ack_off < 16'(occ_ff)) begin
                        mem_re    = 1'b1;
                        mem_raddr = head_ff + ack_off[IDX_W-1:0];
                        state_in  = S_ACK_WR;
                     end
                  end
                  KIND_SERVICE: begin
                     state_in = (deliv_ff >= total_ff) ? S_END : S_RET_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_ACK_WR: begin
            mem_we    = 1'b1;
            mem_waddr = head_ff + ack_off[IDX_W-1:0];
            mem_wdata.acked     = 1'b1;
            mem_wdata.ack_stamp = now_ff;
            state_in  = S_IDLE;
         end
         // retire acked entries from the head
         S_RET_RD: begin
            if (occ_ff == '0) begin
               state_in = S_DIV_INIT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = head_ff;
               state_in  = S_RET_CHK;
            end
         end
         S_RET_CHK: begin
            if (mem_rd_ff.acked) begin
               rtt_in   = rtt_sum[48] ? '1 : rtt_sum[47:0];
               head_in  = head_ff + 1'b1;
               occ_in   = occ_ff - 1'b1;
               if (deliv_ff != 16'hFFFF) deliv_in = deliv_ff + 16'd1;
               state_in = S_RET_RD;
            end else begin
               base_in  = mem_rd_ff.seq;
               state_in = S_DIV_INIT;
            end
         end
         // adaptive timeout
         S_DIV_INIT: begin
            win_i_in = '0;
            win_n_in = (win_cap > occ_ff) ? occ_ff : win_cap;
            if (deliv_ff > DELIV_ADAPT_MIN) begin
               div_num_in = {rtt_ff, 1'b0};
               div_den_in = 26'(deliv_ff) * 26'(US_PER_MS);
               div_rem_in = '0;
               div_q_in   = '0;
               div_cnt_in = 6'd49;
               state_in   = S_DIV;
            end else begin
               tmo_in   = INIT_TIMEOUT_MS;
               state_in = S_WIN_RD;
            end
         end
         S_DIV: begin
            div_rem_in = div_q_last;
            div_q_in   = div_qf;
            div_num_in = {div_num_ff[47:0], 1'b0};
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == 6'd1) begin
               tmo_in   = (|div_qf[48:16]) ? 16'hFFFF : div_qf[15:0];
               state_in = S_WIN_RD;
            end
         end
         // walk the send window
         S_WIN_RD: begin
            if (win_i_ff >= win_n_ff) begin
               state_in = S_END;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = head_ff + win_i_ff[IDX_W-1:0];
               state_in  = S_WIN_LIM;
            end
         end
         S_WIN_LIM: begin
            lim_in   = (27'(mem_rd_ff.timeout_ms) + 27'd1) * 27'(US_PER_MS);
            diff_in  = now_ff - mem_rd_ff.send_time;
            state_in = S_WIN_DEC;
         end
         S_WIN_DEC: begin
            if (skip) begin
               win_i_in = win_i_ff + 1'b1;
               state_in = S_WIN_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_seq_in   = mem_rd_ff.seq;
               rsp_deliv_in = deliv_ff;
               rsp_done_in  = deliv_ff >= total_ff;
               if (mem_rd_ff.attempts > ATTEMPT_LIMIT) begin
                  halted_in   = 1'b1;
                  rsp_ev_in   = EV_ABORT;
                  rsp_att_in  = mem_rd_ff.attempts;
                  rsp_tx_in   = tx_ff;
                  rsp_last_in = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = head_ff + win_i_ff[IDX_W-1:0];
                  mem_wdata.attempts   = mem_rd_ff.attempts + 4'd1;
                  mem_wdata.sent       = 1'b1;
                  mem_wdata.timeout_ms = tmo_ff;
                  mem_wdata.send_time  = now_ff;
                  if (mem_rd_ff.attempts == 4'd0) mem_wdata.first_time = now_ff;
                  tx_in       = (tx_ff != '1) ? tx_ff + 1'b1 : tx_ff;
                  rsp_ev_in   = EV_TX;
                  rsp_att_in  = mem_rd_ff.attempts + 4'd1;
                  rsp_tx_in   = (tx_ff != '1) ? tx_ff + 1'b1 : tx_ff;
                  rsp_last_in = 1'b0;
                  win_i_in    = win_i_ff + 1'b1;
                  state_in    = S_WIN_RD;
               end
            end
         end
         S_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ev_in    = EV_END;
               rsp_seq_in   = '0;
               rsp_att_in   = '0;
               rsp_deliv_in = deliv_ff;
               rsp_tx_in    = tx_ff;
               rsp_done_in  = deliv_ff >= total_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seq_bits_ff <= 5'd8; window_ff <= 5'd4; limit_ff <= 5'd16; total_ff <= 16'd1000;
         head_ff <= '0; occ_ff <= '0; base_ff <= '0; gen_ff <= '0; deliv_ff <= '0;
         tx_ff <= '0; rtt_ff <= '0; halted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seq_bits_ff <= seq_bits_in; window_ff <= window_in; limit_ff <= limit_in;
         total_ff <= total_in;
         head_ff <= head_in; occ_ff <= occ_in; base_ff <= base_in; gen_ff <= gen_in;
         deliv_ff <= deliv_in; tx_ff <= tx_in; rtt_ff <= rtt_in; halted_ff <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in; ack_ff <= ack_in; now_ff <= now_in;
      win_i_ff <= win_i_in; win_n_ff <= win_n_in; tmo_ff <= tmo_in;
      div_num_ff <= div_num_in; div_q_ff <= div_q_in; div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in; div_cnt_ff <= div_cnt_in;
      lim_ff <= lim_in; diff_ff <= diff_in;
      rsp_last_ff <= rsp_last_in; rsp_ev_ff <= rsp_ev_in; rsp_seq_ff <= rsp_seq_in;
      rsp_att_ff <= rsp_att_in; rsp_deliv_ff <= rsp_deliv_in; rsp_tx_ff <= rsp_tx_in;
      rsp_done_ff <= rsp_done_in;
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rd_ff <= mem[mem_raddr];
   end

   `SRS_NEVER(occ_bound_a, occ_ff > OCC_W'(BUF_DEPTH), "occupancy above buffer depth")
   `SRS_ASSERT(halt_sticky_a, halted_ff |=> halted_ff, "halt flag cleared without reset")
   `SRS_NEVER(tx_attempt_a, rsp_valid_ff && rsp_ev_ff == EV_TX && (rsp_att_ff == 4'd0 || rsp_att_ff > 4'd11), "transmit result with bad attempt")
   `SRS_NEVER(tx_last_a, rsp_valid_ff && rsp_ev_ff == EV_TX && rsp_last_ff, "transmit result marked last")

endmodule
